FILE: hw/rtl/i2a_pkg.sv
// Shared types, constants and digit helpers for the signed integer to
// decimal ASCII converter. No dependencies.
package i2a_pkg;

    localparam int unsigned NUM_POS = 10;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    // Powers of ten, wide enough to hold nine times the largest one
    localparam logic [33:0] POW10 [0:NUM_POS-1] = '{
        34'd1,
        34'd10,
        34'd100,
        34'd1000,
        34'd10000,
        34'd100000,
        34'd1000000,
        34'd10000000,
        34'd100000000,
        34'd1000000000
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } back_state_t;

    // Classified number handed from the front to the back
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic [3:0]  top_pos;
    } cmd_t;

    // One character waiting in the result queue
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    // Position of the most significant nonzero digit (0 for values below ten)
    function automatic logic [3:0] top_position(input logic [31:0] mag);
        logic [3:0] pos;
        pos = 4'd0;
        for (int k = 1; k < NUM_POS; k++)
        begin
            if ({2'b00, mag} >= POW10[k])
            begin
                pos = 4'(k);
            end
        end
        return pos;
    endfunction

    // Decimal digit at a position, given a remainder below ten times its weight
    function automatic logic [3:0] digit_at(input logic [31:0] rem, input logic [3:0] pos);
        logic [3:0] dig;
        dig = 4'd0;
        for (int d = 1; d < 10; d++)
        begin
            if ({2'b00, rem} >= POW10[pos] * 34'(d))
            begin
                dig = 4'(d);
            end
        end
        return dig;
    endfunction

    // Amount that a digit removes from the remainder
    function automatic logic [33:0] digit_weight(input logic [3:0] pos, input logic [3:0] dig);
        return POW10[pos] * {30'd0, dig};
    endfunction

endpackage

FILE: hw/rtl/i2a_front.sv
// Front end: accepts integers, forms sign, magnitude and top digit position,
// and holds them in a two-entry queue for the back end. Uses i2a_pkg.
module i2a_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic signed [31:0]  value,
    output logic                full,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output i2a_pkg::cmd_t       cmd
);
    import i2a_pkg::*;

    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    cmd_t        slot_reg [0:1];

    logic [31:0] raw;
    logic [31:0] mag;
    cmd_t        cmd_in;
    logic        do_push;
    logic        do_pop;

    // Classify the incoming number
    always_comb
    begin
        raw            = value;
        mag            = raw[31] ? (~raw + 32'd1) : raw;
        cmd_in.neg     = raw[31];
        cmd_in.mag     = mag;
        cmd_in.top_pos = top_position(mag);
    end

    // Queue handshake
    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Store the classified transaction
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: hw/rtl/i2a_back.sv
// Back end: walks the digits of one number from the top position down, one
// character per cycle while the result queue has room, into a two-entry result queue. Uses i2a_pkg.
module i2a_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  i2a_pkg::cmd_t       cmd,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          ascii_char,
    output logic                last_char
);
    import i2a_pkg::*;

    back_state_t state_reg, state_next;
    logic [31:0] rem_reg, rem_next;
    logic [3:0]  pos_reg, pos_next;

    logic [1:0]  oq_count_reg, oq_count_next;
    logic        oq_wr_reg, oq_wr_next;
    logic        oq_rd_reg, oq_rd_next;
    char_t       oq_slot_reg [0:1];

    logic        oq_full;
    logic        oq_push;
    logic        oq_pop;
    char_t       oq_din;
    char_t       oq_head;
    logic [3:0]  cur_digit;
    logic [33:0] cur_weight;
    logic        last_pos;

    assign cur_digit  = digit_at(rem_reg, pos_reg);
    assign cur_weight = digit_weight(pos_reg, cur_digit);
    assign last_pos   = (pos_reg == 4'd0);
    assign oq_full    = (oq_count_reg == 2'd2);

    // Next state of the digit sequencer
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    rem_next   = cmd.mag;
                    pos_next   = cmd.top_pos;
                    state_next = cmd.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (!oq_full)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (!oq_full)
                begin
                    rem_next = rem_reg - cur_weight[31:0];
                    pos_next = pos_reg - 4'd1;
                    if (last_pos)
                    begin
                        // Pick up the next number without returning to idle
                        if (cmd_valid)
                        begin
                            rem_next   = cmd.mag;
                            pos_next   = cmd.top_pos;
                            state_next = cmd.neg ? ST_SIGN : ST_DIGIT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: take commands, emit characters
    always_comb
    begin
        cmd_ready   = 1'b0;
        oq_push     = 1'b0;
        oq_din.ch   = CHAR_ZERO;
        oq_din.last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_SIGN:
            begin
                oq_push   = !oq_full;
                oq_din.ch = CHAR_MINUS;
            end
            ST_DIGIT:
            begin
                oq_push     = !oq_full;
                oq_din.ch   = CHAR_ZERO + {4'd0, cur_digit};
                oq_din.last = last_pos;
                cmd_ready   = !oq_full && last_pos;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working remainder and position
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        pos_reg <= pos_next;
    end

    // Result queue
    assign oq_head    = oq_slot_reg[oq_rd_reg];
    assign empty      = (oq_count_reg == 2'd0);
    assign ascii_char = oq_head.ch;
    assign last_char  = oq_head.last;
    assign oq_pop     = pop && !empty;

    always_comb
    begin
        oq_wr_next    = oq_push ? ~oq_wr_reg : oq_wr_reg;
        oq_rd_next    = oq_pop ? ~oq_rd_reg : oq_rd_reg;
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + 2'd1;
        end
        else if (oq_pop && !oq_push)
        begin
            oq_count_next = oq_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_count_reg <= 2'd0;
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
        end
        else
        begin
            oq_count_reg <= oq_count_next;
            oq_wr_reg    <= oq_wr_next;
            oq_rd_reg    <= oq_rd_next;
        end
    end

    // Hold each character until popped
    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_slot_reg[oq_wr_reg] <= oq_din;
        end
    end

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on i2a_pkg, i2a_front and i2a_back.
//
//   channel  | handshake      | payload                 | per transaction
//   ---------+----------------+-------------------------+----------------------------
//   input    | push / full    | value[31:0] signed      | one integer
//   result   | pop / empty    | ascii_char[7:0], last_char | one character, MSD first
//
// A number yields 1 to 11 characters. The digit sequencer in the back end emits
// one character a cycle while the result queue has room, and loads the next
// number in the cycle of the last digit. The front end registers each number
// in its queue before the back end sees it. Reset clears both queues and
// returns the sequencer to idle. Without pop the sequencer stalls once the result
// queue fills; the front keeps accepting until its queue of two numbers fills.
module signed_int_to_decimal_ascii (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] value,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         ascii_char,
    output logic               last_char
);
    import i2a_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    i2a_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .value     (value),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    i2a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .pop        (pop),
        .empty      (empty),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

    // Only a minus sign or a decimal digit leaves the block
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (ascii_char == CHAR_MINUS) ||
                   ((ascii_char >= CHAR_ZERO) && (ascii_char <= CHAR_ZERO + 8'd9)))
        else $error("result character outside the minus/digit set");

    // A sign never ends a number
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (ascii_char == CHAR_MINUS)) |-> !last_char)
        else $error("minus sign marked as last character");

    // A popped sign is followed by a digit of the same number
    a_digit_after_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && (ascii_char == CHAR_MINUS)) |=>
            (empty || (ascii_char != CHAR_MINUS)))
        else $error("two minus signs in a row");

    // Only the sequencer idle state or a finished number takes a new command
    a_take_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |->
            (u_back.state_reg == ST_IDLE) ||
            ((u_back.state_reg == ST_DIGIT) && u_back.last_pos))
        else $error("command taken mid-number");

endmodule
